// ===== design/qdbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature detent counter package
// Request types, op and register codes, reset values and the transition table.
// ----------------------------------------------------------------------------
package qdbc_pkg;

    localparam int ValueWidth = 16;
    localparam int SumWidth   = 16;

    // Request opcodes.
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_LOWER_LIMIT = 2'd0;
    localparam logic [1:0] REG_UPPER_LIMIT = 2'd1;
    localparam logic [1:0] REG_START_VALUE = 2'd2;

    localparam logic signed [ValueWidth-1:0] LOWER_LIMIT_RST = 16'sd0;
    localparam logic signed [ValueWidth-1:0] UPPER_LIMIT_RST = 16'sd40;
    localparam logic signed [ValueWidth-1:0] START_VALUE_RST = 16'sd20;
    localparam logic [1:0]                   PIN_HISTORY_RST = 2'b11;

    // Movement per transition code {old_a, old_b, new_a, new_b}.
    // The value 14 marks a transition that skipped a state.
    localparam logic signed [4:0] MOVE_TABLE [16] = '{
        5'sd0,  -5'sd1, 5'sd1,  5'sd14,
        5'sd1,  5'sd0,  5'sd14, -5'sd1,
        -5'sd1, 5'sd14, 5'sd0,  5'sd1,
        5'sd14, 5'sd1,  -5'sd1, 5'sd0
    };

    typedef struct packed {
        logic [1:0] op;
        logic       pin_a;
        logic       pin_b;
    } in_item_t;

    typedef struct packed {
        logic signed [1:0]            step;
        logic signed [ValueWidth-1:0] value;
        logic                         changed;
    } out_item_t;

    typedef struct packed {
        logic signed [1:0]          step;
        logic signed [SumWidth-1:0] sum;
    } detent_res_t;

    typedef struct packed {
        logic                         moved;
        logic signed [ValueWidth-1:0] value;
    } count_res_t;

endpackage

// ===== design/qdbc_detent.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detent detector
// Looks up the pin transition, accumulates it and decides the detent step.
// ----------------------------------------------------------------------------
module qdbc_detent
    import qdbc_pkg::*;
(
    input  logic [1:0]                 pin_history,
    input  logic signed [SumWidth-1:0] move_sum,
    input  logic                       pin_a,
    input  logic                       pin_b,
    output detent_res_t                res
);

    logic [3:0]                code;
    logic signed [4:0]         move;
    logic signed [SumWidth:0]  sum_wide;
    logic                      overflow;

    assign code     = {pin_history, pin_a, pin_b};
    assign move     = MOVE_TABLE[code];
    assign sum_wide = (SumWidth+1)'(move_sum) + (SumWidth+1)'(move);
    assign overflow = sum_wide[SumWidth] ^ sum_wide[SumWidth-1];

    always_comb
    begin
        res.step = 2'sd0;
        res.sum  = '0;
        if (overflow)
        begin
            res.sum = '0;
        end
        else if (sum_wide[1:0] != 2'b00)
        begin
            res.sum = sum_wide[SumWidth-1:0];
        end
        else
        begin
            // At a detent the sum always starts over.
            if (sum_wide == (SumWidth+1)'(4))
                res.step = -2'sd1;
            else if (sum_wide == -(SumWidth+1)'(4))
                res.step = 2'sd1;
        end
    end

endmodule

// ===== design/qdbc_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded counter step
// Applies a detent step to the counter when the limits and range allow it.
// ----------------------------------------------------------------------------
module qdbc_counter
    import qdbc_pkg::*;
(
    input  logic signed [ValueWidth-1:0] value,
    input  logic signed [ValueWidth-1:0] lower_limit,
    input  logic signed [ValueWidth-1:0] upper_limit,
    input  logic signed [1:0]            step,
    output count_res_t                   res
);

    logic may_move;
    logic at_max;
    logic at_min;
    logic in_range;

    assign at_max = (value == {1'b0, {(ValueWidth-1){1'b1}}});
    assign at_min = (value == {1'b1, {(ValueWidth-1){1'b0}}});

    // A counter outside the limits holds; at a limit it may only move inward.
    assign may_move = ((value > lower_limit) && (value < upper_limit))
                   || ((value == upper_limit) && (step == -2'sd1))
                   || ((value == lower_limit) && (step == 2'sd1));
    assign in_range = !((step == 2'sd1) && at_max) && !((step == -2'sd1) && at_min);

    assign res.moved = (step != 2'sd0) && may_move && in_range;
    assign res.value = value + ValueWidth'(step);

endmodule

// ===== design/quadrature_detent_bounded_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature detent bounded counter core
// Decodes encoder pin samples into detent steps that move a bounded counter.
// ----------------------------------------------------------------------------
// Each request passes through an input register and one pass of short logic
// (table lookup, sum add, limit compare) into the result register, so one
// request is taken every cycle while the output side is not stalled, and its
// result is presented from the result register. Every request, sample, restart
// or read, gives exactly one result. Configuration writes take effect at once,
// and the user must make them only while no request is in flight (not enforced).
module quadrature_detent_bounded_counter_core
    import qdbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [ValueWidth-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item
);

    logic signed [ValueWidth-1:0] lower_limit_reg;
    logic signed [ValueWidth-1:0] upper_limit_reg;
    logic signed [ValueWidth-1:0] start_value_reg;

    logic                         in_valid_reg;
    logic                         in_valid_next;
    in_item_t                     in_item_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    out_item_t                    out_item_reg;
    out_item_t                    out_item_next;

    logic [1:0]                   pin_history_reg;
    logic [1:0]                   pin_history_next;
    logic signed [SumWidth-1:0]   move_sum_reg;
    logic signed [SumWidth-1:0]   move_sum_next;
    logic signed [ValueWidth-1:0] count_value_reg;
    logic signed [ValueWidth-1:0] count_value_next;
    logic                         changed_flag_reg;
    logic                         changed_flag_next;

    logic                         advance;
    logic                         accept;
    detent_res_t                  detent;
    count_res_t                   count;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    qdbc_detent u_detent (
        .pin_history (pin_history_reg),
        .move_sum    (move_sum_reg),
        .pin_a       (in_item_reg.pin_a),
        .pin_b       (in_item_reg.pin_b),
        .res         (detent)
    );

    qdbc_counter u_counter (
        .value       (count_value_reg),
        .lower_limit (lower_limit_reg),
        .upper_limit (upper_limit_reg),
        .step        (detent.step),
        .res         (count)
    );

    always_comb
    begin
        pin_history_next  = pin_history_reg;
        move_sum_next     = move_sum_reg;
        count_value_next  = count_value_reg;
        changed_flag_next = changed_flag_reg;
        out_item_next     = out_item_reg;
        if (advance)
        begin
            out_item_next.step = 2'sd0;
            unique case (in_item_reg.op)
                OP_SAMPLE:
                begin
                    pin_history_next   = {in_item_reg.pin_a, in_item_reg.pin_b};
                    move_sum_next      = detent.sum;
                    out_item_next.step = detent.step;
                    if (count.moved)
                    begin
                        count_value_next  = count.value;
                        changed_flag_next = 1'b1;
                    end
                end
                OP_RESTART:
                begin
                    count_value_next  = start_value_reg;
                    changed_flag_next = 1'b0;
                end
                OP_READ:
                begin
                    changed_flag_next = 1'b0;
                end
                default:
                begin
                    // The unused opcode only reports the current state.
                end
            endcase
            out_item_next.value   = count_value_next;
            out_item_next.changed = changed_flag_next;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_limit_reg  <= LOWER_LIMIT_RST;
            upper_limit_reg  <= UPPER_LIMIT_RST;
            start_value_reg  <= START_VALUE_RST;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pin_history_reg  <= PIN_HISTORY_RST;
            move_sum_reg     <= '0;
            count_value_reg  <= START_VALUE_RST;
            changed_flag_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_LOWER_LIMIT: lower_limit_reg <= cfg_data;
                    REG_UPPER_LIMIT: upper_limit_reg <= cfg_data;
                    REG_START_VALUE: start_value_reg <= cfg_data;
                    default:         ;
                endcase
            end
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            pin_history_reg  <= pin_history_next;
            move_sum_reg     <= move_sum_next;
            count_value_reg  <= count_value_next;
            changed_flag_reg <= changed_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_item;
        out_item_reg <= out_item_next;
    end

    // A restart leaves the counter at the start value with the flag clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.op == OP_RESTART)
        |=> (count_value_reg == start_value_reg) && !changed_flag_reg)
        else $error("restart did not load the start value");

    // The changed flag is only set by a sample request that moved the counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(changed_flag_reg)
        |-> $past(advance && (in_item_reg.op == OP_SAMPLE) && count.moved))
        else $error("changed flag set without a counter move");

    // Only sample requests report a nonzero step.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.op != OP_SAMPLE) |=> (out_item_reg.step == 2'sd0))
        else $error("step reported for a non-sample request");

    // Counter state changes only when a request passes to the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(count_value_reg) && $stable(move_sum_reg))
        else $error("counter state changed without a request");

endmodule
